// File: src/lch_pkg.sv
// shared types, constants and helper functions for the letter-class histogram
package lch_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int NUM_BINS    = 27;
	localparam int BIN_W       = 5;
	localparam int LABEL_W     = 7;
	localparam int OUT_CNT_W   = 16;
	localparam int NZ_W        = 5;
	localparam int CODE_W      = 8;
	localparam int KIND_W      = 2;
	localparam int RES_PAD_W   = 7;
	localparam int RES_W       = RES_PAD_W + NZ_W + 2 * OUT_CNT_W + LABEL_W + BIN_W;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [BIN_W-1:0]       bin_t;
	typedef logic [CODE_W-1:0]      code_t;

	localparam count_t CNT_MAX   = {COUNT_WIDTH{1'b1}};
	localparam bin_t   OTHER_BIN = BIN_W'(NUM_BINS - 1);
	localparam bin_t   LAST_BIN  = BIN_W'(NUM_BINS - 1);
	localparam bin_t   BINS_END  = BIN_W'(NUM_BINS);

	localparam code_t CHAR_LOWER_A = 8'h61;
	localparam code_t CHAR_LOWER_Z = 8'h7a;
	localparam code_t CHAR_UPPER_A = 8'h41;
	localparam code_t CHAR_UPPER_Z = 8'h5a;
	localparam code_t CHAR_DOT     = 8'h2e;

	typedef enum logic [KIND_W-1:0] {
		KIND_COUNT = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// classification of one text byte
	typedef struct packed {
		logic hit;
		bin_t bin;
	} class_t;

	// read request from the readout sequencer
	typedef struct packed {
		logic busy;
		bin_t addr;
	} scan_req_t;

	// one readout result, last field in the low bits
	typedef struct packed {
		logic [RES_PAD_W-1:0] pad;
		logic [NZ_W-1:0]      nonzero_bins;
		logic [OUT_CNT_W-1:0] max_count;
		logic [OUT_CNT_W-1:0] bin_count;
		logic [LABEL_W-1:0]   bin_label;
		bin_t                 bin_index;
	} result_t;

	function automatic class_t classify(code_t c);
		class_t r;
		code_t  d;
		r.hit = 1'b0;
		r.bin = OTHER_BIN;
		d     = '0;
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			d     = c - CHAR_LOWER_A;
			r.hit = 1'b1;
			r.bin = d[BIN_W-1:0];
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			d     = c - CHAR_UPPER_A;
			r.hit = 1'b1;
			r.bin = d[BIN_W-1:0];
		end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
			r.hit = 1'b1;
		end else if ((c >= 8'h21 && c <= 8'h2f) || (c >= 8'h3a && c <= 8'h40) ||
			(c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e)) begin
			r.hit = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [LABEL_W-1:0] bin_label(bin_t b);
		code_t l;
		if (b == OTHER_BIN) begin
			l = CHAR_DOT;
		end else begin
			l = CHAR_UPPER_A + {{(CODE_W-BIN_W){1'b0}}, b};
		end
		return l[LABEL_W-1:0];
	endfunction

	// low bits of a count, zero extended when the counter is narrow
	function automatic logic [OUT_CNT_W-1:0] count_out(count_t c);
		logic [COUNT_WIDTH+OUT_CNT_W-1:0] x;
		x = {{OUT_CNT_W{1'b0}}, c};
		return x[OUT_CNT_W-1:0];
	endfunction

endpackage

// File: src/lch_ram.sv
// generic single-write, single-read synchronous ram with registered read
module lch_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/lch_update.sv
// count path: read-modify-write of one bin per text byte, with forwarding and valid bits
module lch_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              count_en,
	input  lch_pkg::bin_t                     count_bin,
	input  logic                              clear_en,
	input  lch_pkg::count_t                   rdata,
	output logic [lch_pkg::NUM_BINS-1:0]      valid,
	output logic                              we,
	output lch_pkg::bin_t                     waddr,
	output lch_pkg::count_t                   wdata
);

	import lch_pkg::*;

	logic                vld_s1;
	bin_t                bin_s1;
	logic                fwd_vld_q;
	bin_t                fwd_bin_q;
	count_t              fwd_val_q;
	logic [NUM_BINS-1:0] valid_q;
	count_t              cur;
	count_t              nxt;

	// the write of the previous byte lands in the same edge as this read
	always_comb begin
		if (fwd_vld_q && fwd_bin_q == bin_s1) begin
			cur = fwd_val_q;
		end else if (valid_q[bin_s1]) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
		nxt = (cur == CNT_MAX) ? cur : cur + count_t'(1);
	end

	assign we    = vld_s1;
	assign waddr = bin_s1;
	assign wdata = nxt;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
			valid_q   <= '0;
		end else begin
			vld_s1 <= count_en;
			if (clear_en) begin
				valid_q   <= '0;
				fwd_vld_q <= 1'b0;
			end else begin
				fwd_vld_q <= vld_s1;
				if (vld_s1) begin
					valid_q[bin_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (count_en) begin
			bin_s1 <= count_bin;
		end
		if (vld_s1) begin
			fwd_bin_q <= bin_s1;
			fwd_val_q <= nxt;
		end
	end

endmodule

// File: src/lch_readout.sv
// readout sequencer: repeated selection scans over the bin ram, one result per pass
module lch_readout (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  lch_pkg::count_t              rdata,
	input  logic [lch_pkg::NUM_BINS-1:0] valid,
	output lch_pkg::scan_req_t           scan,
	output logic                         res_valid,
	input  logic                         res_ready,
	output lch_pkg::result_t             res,
	output logic                         res_last
);

	import lch_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t          state_q;
	bin_t            rank_q;
	bin_t            scan_idx_q;
	logic            sv_s1;
	bin_t            sbin_s1;
	count_t          prev_cnt_q;
	bin_t            prev_bin_q;
	logic            best_vld_q;
	count_t          best_cnt_q;
	bin_t            best_bin_q;
	count_t          max_q;
	logic [NZ_W-1:0] nz_q;
	logic            out_vld_q;
	result_t         out_q;
	logic            out_last_q;

	logic   issuing;
	count_t scan_cnt;
	logic   cand;
	logic   take;

	assign issuing = (state_q == S_SCAN) && (scan_idx_q != BINS_END);

	always_comb begin
		scan_cnt = valid[sbin_s1] ? rdata : '0;
		// key is {count, bin}; only keys above the last emitted one qualify
		cand = (rank_q == '0) || (scan_cnt > prev_cnt_q) ||
			(scan_cnt == prev_cnt_q && sbin_s1 > prev_bin_q);
		take = sv_s1 && cand && (!best_vld_q || scan_cnt < best_cnt_q);
	end

	assign scan.busy = (state_q != S_IDLE);
	assign scan.addr = issuing ? scan_idx_q : '0;
	assign res_valid = out_vld_q;
	assign res       = out_q;
	assign res_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rank_q     <= '0;
			scan_idx_q <= '0;
			sv_s1      <= 1'b0;
			sbin_s1    <= '0;
			prev_cnt_q <= '0;
			prev_bin_q <= '0;
			best_vld_q <= 1'b0;
			best_cnt_q <= '0;
			best_bin_q <= '0;
			max_q      <= '0;
			nz_q       <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			sv_s1   <= issuing;
			sbin_s1 <= scan_idx_q;
			if (out_vld_q && res_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q    <= S_SCAN;
						rank_q     <= '0;
						scan_idx_q <= '0;
						best_vld_q <= 1'b0;
						max_q      <= '0;
						nz_q       <= '0;
					end
				end
				S_SCAN: begin
					if (issuing) begin
						scan_idx_q <= scan_idx_q + bin_t'(1);
					end
					if (take) begin
						best_vld_q <= 1'b1;
						best_cnt_q <= scan_cnt;
						best_bin_q <= sbin_s1;
					end
					// first pass also gathers the summary figures
					if (sv_s1 && rank_q == '0) begin
						if (scan_cnt > max_q) begin
							max_q <= scan_cnt;
						end
						if (scan_cnt != '0) begin
							nz_q <= nz_q + NZ_W'(1);
						end
					end
					if (sv_s1 && sbin_s1 == LAST_BIN) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_vld_q || res_ready) begin
						out_vld_q          <= 1'b1;
						out_q.pad          <= '0;
						out_q.nonzero_bins <= nz_q;
						out_q.max_count    <= count_out(max_q);
						out_q.bin_count    <= count_out(best_cnt_q);
						out_q.bin_label    <= bin_label(best_bin_q);
						out_q.bin_index    <= best_bin_q;
						out_last_q         <= (rank_q == LAST_BIN);
						if (rank_q == LAST_BIN) begin
							state_q <= S_IDLE;
						end else begin
							state_q    <= S_SCAN;
							rank_q     <= rank_q + bin_t'(1);
							prev_cnt_q <= best_cnt_q;
							prev_bin_q <= best_bin_q;
							best_vld_q <= 1'b0;
							scan_idx_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/letter_class_histogram.sv
// top level of the letter-class histogram: stream ports, bin ram and the two control paths
//
// text bytes are classified into 27 bins: letters a-z and A-Z with case folded go to
// bins 0-25, whitespace (0x09-0x0d, 0x20) and punctuation go to bin 26, every other
// byte is dropped. counts saturate at all ones. the bins live in one 27-entry
// synchronous ram; a count transaction reads its bin on acceptance and writes the
// incremented value in the following cycle, and a one-entry forwarding register
// covers a back-to-back byte of the same bin, so count and clear transactions are
// taken at one per cycle while no readout runs. on a clear transaction a flip-flop
// valid bit per bin is dropped and an invalid bin reads as zero, so no clearing
// sweep is needed, also not after reset. a readout transaction emits all 27 bins in
// ascending count order, equal counts in bin order, each result with its label,
// count, the largest count, the number of nonzero bins and tlast on the final bin.
// the sort is a selection scan over the single ram read port: each result costs one
// pass of 27 reads, the registered read and an emit step, and the emit waits while
// the output side stalls. no input transaction is taken while a readout runs. kind
// code 3 is accepted and ignored.
module letter_class_histogram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [lch_pkg::CODE_W-1:0]  s_axis_tdata,  // [7:0] char_code
	input  logic [lch_pkg::KIND_W-1:0]  s_axis_tuser,  // [1:0] kind
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [4:0] bin_index, [11:5] bin_label, [27:12] bin_count, [43:28] max_count,
	// [48:44] nonzero_bins, [55:49] zero
	output logic [lch_pkg::RES_W-1:0]   m_axis_tdata,
	output logic                        m_axis_tlast
);

	import lch_pkg::*;

	logic                s_xfer;
	logic                count_en;
	logic                clear_en;
	logic                read_en;
	class_t              cls;
	scan_req_t           scan;
	logic [NUM_BINS-1:0] valid;
	logic                we;
	bin_t                waddr;
	count_t              wdata;
	bin_t                raddr;
	count_t              rdata;
	result_t             res;

	// input side is closed only while a readout runs
	assign s_axis_tready = !scan.busy;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	assign cls      = classify(s_axis_tdata);
	assign count_en = s_xfer && (s_axis_tuser == KIND_COUNT) && cls.hit;
	assign clear_en = s_xfer && (s_axis_tuser == KIND_CLEAR);
	assign read_en  = s_xfer && (s_axis_tuser == KIND_READ);

	// the readout owns the read port while busy, otherwise the incoming byte's bin
	assign raddr = scan.busy ? scan.addr : cls.bin;

	lch_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	lch_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.count_en  (count_en),
		.count_bin (cls.bin),
		.clear_en  (clear_en),
		.rdata     (rdata),
		.valid     (valid),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata)
	);

	lch_readout u_readout (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (read_en),
		.rdata     (rdata),
		.valid     (valid),
		.scan      (scan),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res),
		.res_last  (m_axis_tlast)
	);

	assign m_axis_tdata = res;

endmodule
